// File: src/rdq_pkg.sv
// Package for the ring deque: request codes, status codes, default sizes.
// No dependencies.
`default_nettype none
package rdq_pkg;
  localparam int unsigned CapacityDef = 256;
  localparam int unsigned KeyWidthDef = 32;

  typedef enum logic [3:0] {
    FN_PUSH_BACK   = 4'd0,
    FN_PUSH_FRONT  = 4'd1,
    FN_INSERT      = 4'd2,
    FN_POP_BACK    = 4'd3,
    FN_POP_FRONT   = 4'd4,
    FN_REMOVE      = 4'd5,
    FN_READ        = 4'd6,
    FN_REPLACE     = 4'd7,
    FN_CLEAR       = 4'd8,
    FN_SORT_INS    = 4'd9,
    FN_SORT_INS_RP = 4'd10,
    FN_SEARCH      = 4'd11
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_INDEX = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;
endpackage
`default_nettype wire

// File: src/rdq_mem.sv
// Slot storage of the ring deque: one write port, one registered read port.
// Uses no package.
`default_nettype none
module rdq_mem #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// File: src/ring_deque_with_sorted_insert.sv
// Ring deque with sorted insert and binary search over one slot memory.
// Clear, unused codes and rejected requests go straight to done; pop, read and replace
// read one slot; remove, push and insert move the shorter side (at most about CAPACITY/2
// moves); search reads one slot per probe (about log2(CAPACITY)+1 probes), sorted insert
// then moves like insert, and replace on match writes the new key over the found one.
// One request at a time, busy high meanwhile. Reset clears state, head, count and done only.
`default_nettype none
module ring_deque_with_sorted_insert
  #(
  parameter int unsigned CAPACITY  = rdq_pkg::CapacityDef,
  parameter int unsigned KEY_WIDTH = rdq_pkg::KeyWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  func_i,
  input  wire logic [8:0]  position_i,
  input  wire logic [31:0] key_in_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [31:0]      key_out_o,
  output logic [8:0]       where_o,
  output logic             replaced_o,
  output logic [8:0]       count_out_o
);
  import rdq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned IW = CW + 1; // signed search bounds

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_MOVE_RD, S_MOVE_WR, S_FINAL_WR,
    S_RD, S_RD_WAIT, S_SRCH_RD, S_SRCH_CMP, S_DONE
  } state_e;

  state_e               state_q;
  logic [AW-1:0]        head_q;
  logic [CW-1:0]        fill_q;
  func_e                func_q;
  logic [CW-1:0]        pos_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [CW-1:0]        k_q;      // move cursor
  logic                 dir_q;    // 1: front side moves on insert, back side on remove
  logic signed [IW-1:0] lo_q, hi_q, mid_q;
  logic                 last_q;   // probe is the lo>=hi probe
  logic [2:0]           status_q;
  logic [KEY_WIDTH-1:0] kout_q;
  logic [CW-1:0]        where_q;
  logic                 repl_q;
  logic [CW-1:0]        ins_q;    // insert point
  logic [CW-1:0]        end_q;    // move stop point
  logic                 wb_q;     // RD phase writes key back (replace)

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [KEY_WIDTH-1:0] wdata, rdata;

  rdq_mem #(.Depth(CAPACITY), .Width(KEY_WIDTH)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW:0] k);
    logic [CW+1:0] s;
    s = {{(CW+2-AW){1'b0}}, h} + {1'b0, k};
    // k < 2*CAPACITY here, so two compare/subtracts cover the wrap
    if (s >= (CW+2)'(CAPACITY)) s = s - (CW+2)'(CAPACITY);
    if (s >= (CW+2)'(CAPACITY)) s = s - (CW+2)'(CAPACITY);
    return s[AW-1:0];
  endfunction

  logic [CW-1:0] pos_in;
  assign pos_in = (position_i > 9'(CAPACITY)) ? CW'(CAPACITY) + CW'(1) : CW'(position_i);
  logic pos_big;
  assign pos_big = (position_i > 9'(CAPACITY));

  logic signed [IW-1:0] midc;
  assign midc = (lo_q + hi_q) >>> 1; // lo,hi >= 0 here when used

  // index probed by the current search step
  logic signed [IW-1:0] probe;
  assign probe = (lo_q >= hi_q) ? lo_q : midc;

  // memory addressing per state
  always_comb begin
    we = 1'b0; waddr = '0; wdata = key_q; raddr = '0;
    unique case (state_q)
      S_MOVE_RD: begin
        // dir 1: slot[k-1] <- slot[k]; dir 0: slot[k] <- slot[k-1]
        if (dir_q) raddr = phys(head_q, {1'b0, k_q});
        else raddr = phys(head_q, {1'b0, k_q} - (CW+1)'(1));
      end
      S_MOVE_WR: begin
        we = 1'b1; wdata = rdata;
        if (dir_q) waddr = phys(head_q, {1'b0, k_q} + (CW+1)'(CAPACITY - 1));
        else waddr = phys(head_q, {1'b0, k_q});
      end
      S_FINAL_WR: begin
        // front side: the new element lands one slot before the old index
        we = 1'b1;
        if (dir_q) waddr = phys(head_q, {1'b0, ins_q} + (CW+1)'(CAPACITY - 1));
        else waddr = phys(head_q, {1'b0, ins_q});
      end
      S_RD: raddr = phys(head_q, {1'b0, pos_q});
      S_RD_WAIT: begin
        we = wb_q; waddr = phys(head_q, {1'b0, pos_q});
      end
      S_SRCH_RD: raddr = phys(head_q, (CW+1)'(probe[CW-1:0]));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; head_q <= '0; fill_q <= '0; done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: if (start) begin
          func_q <= func_e'(func_i);
          pos_q <= pos_big ? '1 : pos_in;
          key_q <= KEY_WIDTH'(key_in_i);
          status_q <= ST_OK; kout_q <= '0; where_q <= '0; repl_q <= 1'b0;
          state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          state_q <= S_DONE;
          wb_q <= 1'b0;
          case (func_q)
            FN_PUSH_BACK, FN_PUSH_FRONT, FN_INSERT: begin
              if (func_q == FN_INSERT && pos_q > fill_q) status_q <= ST_BAD_INDEX;
              else if (fill_q >= CW'(CAPACITY)) status_q <= ST_FULL;
              else begin
                ins_q <= (func_q == FN_PUSH_BACK) ? fill_q :
                         (func_q == FN_PUSH_FRONT) ? '0 : pos_q;
                where_q <= (func_q == FN_PUSH_BACK) ? fill_q :
                           (func_q == FN_PUSH_FRONT) ? '0 : pos_q;
                begin : setup
                  logic [CW-1:0] i;
                  i = (func_q == FN_PUSH_BACK) ? fill_q :
                      (func_q == FN_PUSH_FRONT) ? '0 : pos_q;
                  if (i < (fill_q >> 1)) begin
                    dir_q <= 1'b1; k_q <= '0; end_q <= i;
                    state_q <= (i == '0) ? S_FINAL_WR : S_MOVE_RD;
                  end else begin
                    dir_q <= 1'b0; k_q <= fill_q; end_q <= i;
                    state_q <= (fill_q == i) ? S_FINAL_WR : S_MOVE_RD;
                  end
                end
              end
            end
            FN_POP_BACK, FN_POP_FRONT: begin
              if (fill_q == '0) status_q <= ST_EMPTY;
              else begin
                pos_q <= (func_q == FN_POP_BACK) ? fill_q - CW'(1) : '0;
                state_q <= S_RD;
              end
            end
            FN_REMOVE, FN_READ, FN_REPLACE: begin
              if (pos_q >= fill_q) status_q <= ST_BAD_INDEX;
              else if (func_q == FN_REMOVE) begin
                if (pos_q < (fill_q >> 1)) begin
                  dir_q <= 1'b0; k_q <= pos_q; // slot[k] <- slot[k-1], k down to 1
                  state_q <= (pos_q == '0) ? S_DONE : S_MOVE_RD;
                  end_q <= '0;
                  ins_q <= '1; // marks remove
                  if (pos_q == '0) begin
                    head_q <= phys(head_q, (CW+1)'(1)); fill_q <= fill_q - CW'(1);
                  end
                end else begin
                  dir_q <= 1'b1; k_q <= pos_q + CW'(1); // slot[k-1] <- slot[k]
                  end_q <= fill_q;
                  ins_q <= '1;
                  if (pos_q + CW'(1) >= fill_q) begin
                    fill_q <= fill_q - CW'(1); state_q <= S_DONE;
                  end else state_q <= S_MOVE_RD;
                end
              end else state_q <= S_RD;
            end
            FN_CLEAR: begin
              head_q <= '0; fill_q <= '0;
            end
            FN_SORT_INS, FN_SORT_INS_RP, FN_SEARCH: begin
              if (fill_q == '0) begin
                if (func_q == FN_SEARCH) status_q <= ST_NOT_FOUND;
                else begin
                  ins_q <= '0; where_q <= '0; dir_q <= 1'b0; state_q <= S_FINAL_WR;
                end
              end else begin
                lo_q <= '0; hi_q <= IW'(fill_q) - IW'(1);
                mid_q <= '0; last_q <= (fill_q == CW'(1));
                state_q <= S_SRCH_RD;
              end
            end
            default: ;
          endcase
        end
        S_MOVE_RD: state_q <= S_MOVE_WR;
        S_MOVE_WR: begin
          if (ins_q == '1 && !dir_q) begin
            // remove, front side: k down to 1
            if (k_q == CW'(1)) begin
              head_q <= phys(head_q, (CW+1)'(1)); fill_q <= fill_q - CW'(1);
              state_q <= S_DONE;
            end else begin k_q <= k_q - CW'(1); state_q <= S_MOVE_RD; end
          end else if (ins_q == '1) begin
            // remove, back side
            if (k_q + CW'(1) >= end_q) begin
              fill_q <= fill_q - CW'(1); state_q <= S_DONE;
            end else begin k_q <= k_q + CW'(1); state_q <= S_MOVE_RD; end
          end else if (dir_q) begin
            if (k_q + CW'(1) >= end_q) state_q <= S_FINAL_WR;
            else begin k_q <= k_q + CW'(1); state_q <= S_MOVE_RD; end
          end else begin
            if (k_q - CW'(1) <= end_q) state_q <= S_FINAL_WR;
            else begin k_q <= k_q - CW'(1); state_q <= S_MOVE_RD; end
          end
        end
        S_FINAL_WR: begin
          // front-side insert moved the head back by one
          if (dir_q) head_q <= phys(head_q, (CW+1)'(CAPACITY - 1));
          fill_q <= fill_q + CW'(1);
          state_q <= S_DONE;
        end
        S_RD: begin
          wb_q <= (func_q == FN_REPLACE) || (func_q == FN_SORT_INS_RP);
          state_q <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          // replace on match arrives here with the old key already held
          if (!repl_q) kout_q <= rdata;
          if (func_q == FN_POP_BACK) fill_q <= fill_q - CW'(1);
          if (func_q == FN_POP_FRONT) begin
            fill_q <= fill_q - CW'(1); head_q <= phys(head_q, (CW+1)'(1));
          end
          state_q <= S_DONE;
        end
        S_SRCH_RD: begin
          mid_q <= probe;
          last_q <= (lo_q >= hi_q);
          state_q <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          state_q <= S_SRCH_RD;
          begin : cmp
            logic found;
            logic [CW-1:0] idx;
            found = 1'b0; idx = CW'(mid_q);
            if (last_q) begin
              if (rdata == key_q) found = 1'b1;
              else if (rdata < key_q) idx = CW'(mid_q) + CW'(1);
            end else if (rdata == key_q) found = 1'b1;
            if (last_q || found) begin
              state_q <= S_DONE;
              if (func_q == FN_SEARCH) begin
                if (found) where_q <= idx; else status_q <= ST_NOT_FOUND;
              end else if (found && func_q == FN_SORT_INS_RP) begin
                kout_q <= rdata; repl_q <= 1'b1; where_q <= idx;
                pos_q <= idx; wb_q <= 1'b1; state_q <= S_RD_WAIT;
              end else begin
                if (found) idx = idx + CW'(1);
                if (fill_q >= CW'(CAPACITY)) status_q <= ST_FULL;
                else begin
                  where_q <= idx; ins_q <= idx;
                  if (idx < (fill_q >> 1)) begin
                    dir_q <= 1'b1; k_q <= '0; end_q <= idx;
                    state_q <= (idx == '0) ? S_FINAL_WR : S_MOVE_RD;
                  end else begin
                    dir_q <= 1'b0; k_q <= fill_q; end_q <= idx;
                    state_q <= (fill_q == idx) ? S_FINAL_WR : S_MOVE_RD;
                  end
                end
              end
            end else if (key_q < rdata) hi_q <= mid_q - IW'(1);
            else lo_q <= mid_q + IW'(1);
          end
        end
        S_DONE: begin
          done_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign status_o    = status_q;
  assign key_out_o   = 32'(kout_q);
  assign where_o     = 9'(where_q);
  assign replaced_o  = repl_q;
  assign count_out_o = 9'(fill_q);
endmodule
`default_nettype wire

// File: tb/rdq_checker.sv
// Checker for the ring deque: watches request and result transactions, predicts
// each result from its own copy of the ring, and counts mismatches.
// Depends on rdq_pkg for the request and status codes.
`timescale 1ns / 1ps
module rdq_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [3:0]  func_i,
  input  logic [8:0]  position_i,
  input  logic [31:0] key_in_i,
  input  logic        done_i,
  input  logic [2:0]  status_i,
  input  logic [31:0] key_out_i,
  input  logic [8:0]  where_i,
  input  logic        replaced_i,
  input  logic [8:0]  count_out_i,
  output int          errors_o,
  output int          pending_o
);
  import rdq_pkg::*;

  localparam int Depth = 256;
  localparam int FifoDepth = 64;

  typedef struct packed {
    status_e     st;
    logic [31:0] kout;
    logic [8:0]  wh;
    logic        rp;
    logic [8:0]  cnt;
  } deque_result_t;

  logic [31:0]   ring_mem [Depth];
  logic [7:0]    front_q;
  logic [8:0]    n_elems;
  deque_result_t expected_results [FifoDepth];
  int            wr_cnt;
  int            rd_cnt;

  assign pending_o = wr_cnt - rd_cnt;

  function automatic int slot(int k);
    return (int'(front_q) + k) % Depth;
  endfunction

  function automatic int slot_prev(int k);
    return (int'(front_q) + k + Depth - 1) % Depth;
  endfunction

  // Probe order must match the block: duplicates resolve to the first hit.
  function automatic int probe_search(logic [31:0] key, output bit found);
    int lo;
    int hi;
    int mid;
    logic [31:0] v;
    lo = 0;
    hi = int'(n_elems) - 1;
    found = 0;
    while (1) begin
      if (lo >= hi) begin
        v = ring_mem[slot(lo)];
        if (v == key) begin
          found = 1;
          return lo;
        end
        return (v < key) ? lo + 1 : lo;
      end
      mid = (lo + hi) / 2;
      v = ring_mem[slot(mid)];
      if (key < v) hi = mid - 1;
      else if (key == v) begin
        found = 1;
        return mid;
      end else lo = mid + 1;
    end
  endfunction

  // Shorter side moves: front half shifts toward the previous slot.
  function automatic void shift_in(int i, logic [31:0] key);
    int k;
    if (i < int'(n_elems) / 2) begin
      for (k = 0; k < i; k++) ring_mem[slot_prev(k)] = ring_mem[slot(k)];
      front_q = 8'(slot_prev(0));
    end else begin
      for (k = int'(n_elems); k > i; k--) ring_mem[slot(k)] = ring_mem[slot(k - 1)];
    end
    ring_mem[slot(i)] = key;
    n_elems++;
  endfunction

  function automatic deque_result_t apply_request(logic [3:0] f, logic [8:0] pos,
                                                  logic [31:0] key);
    deque_result_t r;
    bit found;
    int idx;
    int k;
    r = '{st: ST_OK, kout: '0, wh: '0, rp: 1'b0, cnt: '0};
    case (f)
      FN_PUSH_BACK, FN_PUSH_FRONT: begin
        if (n_elems >= Depth) r.st = ST_FULL;
        else begin
          r.wh = (f == FN_PUSH_BACK) ? n_elems : 9'd0;
          shift_in(int'(r.wh), key);
        end
      end
      FN_INSERT: begin
        if (pos > n_elems) r.st = ST_BAD_INDEX;
        else if (n_elems >= Depth) r.st = ST_FULL;
        else begin
          r.wh = pos;
          shift_in(int'(pos), key);
        end
      end
      FN_POP_BACK: begin
        if (n_elems == 0) r.st = ST_EMPTY;
        else begin
          r.kout = ring_mem[slot(int'(n_elems) - 1)];
          n_elems--;
        end
      end
      FN_POP_FRONT: begin
        if (n_elems == 0) r.st = ST_EMPTY;
        else begin
          r.kout = ring_mem[slot(0)];
          n_elems--;
          front_q = 8'(slot(1));
        end
      end
      FN_REMOVE: begin
        if (pos >= n_elems) r.st = ST_BAD_INDEX;
        else begin
          if (int'(pos) < int'(n_elems) / 2) begin
            for (k = int'(pos); k > 0; k--) ring_mem[slot(k)] = ring_mem[slot_prev(k)];
            front_q = 8'(slot(1));
          end else begin
            for (k = int'(pos); k + 1 < int'(n_elems); k++)
              ring_mem[slot(k)] = ring_mem[slot(k + 1)];
          end
          n_elems--;
        end
      end
      FN_READ: begin
        if (pos >= n_elems) r.st = ST_BAD_INDEX;
        else r.kout = ring_mem[slot(int'(pos))];
      end
      FN_REPLACE: begin
        if (pos >= n_elems) r.st = ST_BAD_INDEX;
        else begin
          r.kout = ring_mem[slot(int'(pos))];
          ring_mem[slot(int'(pos))] = key;
        end
      end
      FN_CLEAR: begin
        front_q = '0;
        n_elems = '0;
      end
      FN_SORT_INS, FN_SORT_INS_RP: begin
        idx = 0;
        found = 0;
        if (n_elems != 0) idx = probe_search(key, found);
        if (found && f == FN_SORT_INS_RP) begin
          r.kout = ring_mem[slot(idx)];
          ring_mem[slot(idx)] = key;
          r.rp = 1'b1;
          r.wh = 9'(idx);
        end else begin
          if (found) idx++;
          if (n_elems >= Depth) r.st = ST_FULL;
          else begin
            r.wh = 9'(idx);
            shift_in(idx, key);
          end
        end
      end
      FN_SEARCH: begin
        if (n_elems == 0) r.st = ST_NOT_FOUND;
        else begin
          idx = probe_search(key, found);
          if (found) r.wh = 9'(idx);
          else r.st = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    r.cnt = n_elems;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t exp_r;
    deque_result_t act_r;
    if (!rst_ni) begin
      front_q = '0;
      n_elems = '0;
      wr_cnt = 0;
      rd_cnt = 0;
      errors_o <= 0;
    end else begin
      if (done_i) begin
        act_r = '{st: status_e'(status_i), kout: key_out_i, wh: where_i,
                  rp: replaced_i, cnt: count_out_i};
        if (wr_cnt == rd_cnt) begin
          if (errors_o < 10) $display("unexpected result transaction: %p", act_r);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = expected_results[rd_cnt % FifoDepth];
          rd_cnt++;
          if (act_r.st !== exp_r.st || act_r.kout !== exp_r.kout || act_r.wh !== exp_r.wh ||
              act_r.rp !== exp_r.rp || act_r.cnt !== exp_r.cnt) begin
            if (errors_o < 10) $display("mismatch: expected %p actual %p", exp_r, act_r);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_results[wr_cnt % FifoDepth] = apply_request(func_i, position_i, key_in_i);
        wr_cnt++;
      end
    end
  end
endmodule

// File: tb/tb_top.sv
// Top of the ring deque testbench: clock, reset, request stimulus and verdict.
// Depends on rdq_pkg, ring_deque_with_sorted_insert and rdq_checker.
`timescale 1ns / 1ps
module tb_top;
  import rdq_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam logic [3:0] FnUnusedLo = 4'd12;
  localparam logic [3:0] FnUnusedHi = 4'd15;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [3:0]  func;
  logic [8:0]  position;
  logic [31:0] key_in;
  logic        done;
  logic [2:0]  status;
  logic [31:0] key_out;
  logic [8:0]  where_idx;
  logic        replaced;
  logic [8:0]  count_out;
  int          errors;
  int          pending;
  int          cycles = 0;
  int          fill_seen = 0;
  bit          no_gaps;

  ring_deque_with_sorted_insert i_dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .func_i(func), .position_i(position), .key_in_i(key_in),
    .done_o(done), .status_o(status), .key_out_o(key_out), .where_o(where_idx),
    .replaced_o(replaced), .count_out_o(count_out)
  );

  rdq_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .func_i(func), .position_i(position), .key_in_i(key_in),
    .done_i(done), .status_i(status), .key_out_i(key_out), .where_i(where_idx),
    .replaced_i(replaced), .count_out_i(count_out),
    .errors_o(errors), .pending_o(pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Element count as last reported; only steers the stimulus mix.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (done) fill_seen <= int'(count_out);
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance, or after a random gap with start low.
  task automatic send(logic [3:0] f, logic [8:0] pos, logic [31:0] key);
    int r;
    int gap;
    bit taken;
    func = f;
    position = pos;
    key_in = key;
    start = 1'b1;
    do begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end while (!taken);
    r = $urandom_range(0, 99);
    gap = (no_gaps || r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [8:0] pick_pos();
    if ($urandom_range(0, 9) == 0) return 9'($urandom_range(0, 511));
    return 9'($urandom_range(0, fill_seen + 1));
  endfunction

  function automatic logic [31:0] pick_key(bit narrow);
    if (narrow) return $urandom_range(0, 40);
    case ($urandom_range(0, 5))
      0: return 32'hFFFF_FFFF;
      1: return '0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int mode;
    int r;
    bit narrow;
    start = 1'b0;
    func = '0;
    position = '0;
    key_in = '0;
    no_gaps = 0;
    rst_n = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Empty-deque corners, then each request on a few elements.
    send(FN_POP_BACK, 9'd0, '0);
    send(FN_POP_FRONT, 9'd0, '0);
    send(FN_READ, 9'd0, '0);
    send(FN_REMOVE, 9'd0, '0);
    send(FN_REPLACE, 9'd0, 32'h1234);
    send(FN_SEARCH, 9'd0, 32'd7);
    send(FN_INSERT, 9'd1, 32'd5);
    send(FN_INSERT, 9'd0, 32'd20);
    send(FN_PUSH_BACK, 9'h1FF, 32'hFFFF_FFFF);
    send(FN_PUSH_FRONT, 9'd0, 32'd0);
    send(FN_INSERT, 9'd2, 32'hA5A5_5A5A);
    send(FN_READ, 9'd3, '0);
    send(FN_READ, 9'd4, '0);
    send(FN_REPLACE, 9'd2, 32'd30);
    send(FN_REMOVE, 9'd1, '0);
    send(FN_SORT_INS, 9'd0, 32'd25);
    send(FN_SORT_INS, 9'd0, 32'd25);
    send(FN_SORT_INS_RP, 9'd0, 32'd30);
    send(FN_SORT_INS_RP, 9'd0, 32'd1);
    send(FN_SEARCH, 9'd0, 32'd25);
    send(FN_SEARCH, 9'd0, 32'd26);
    send(FnUnusedLo, 9'h1FF, 32'hFFFF_FFFF);
    send(FnUnusedHi, 9'd0, '0);
    send(FN_CLEAR, 9'd0, '0);
    send(FN_POP_BACK, 9'd0, '0);

    // Hold off until the block has drained.
    start = 1'b0;
    while (pending != 0) @(negedge clk);

    // Fill to capacity, then every full-deque corner.
    no_gaps = 1;
    for (int i = 0; i < 256; i++)
      send(FN_SORT_INS, 9'd0, 32'(i / 2));
    no_gaps = 0;
    send(FN_PUSH_BACK, 9'd0, 32'd1);
    send(FN_PUSH_FRONT, 9'd0, 32'd1);
    send(FN_INSERT, 9'd300, 32'd1);
    send(FN_INSERT, 9'd10, 32'd1);
    send(FN_SORT_INS, 9'd0, 32'd9);
    send(FN_SORT_INS_RP, 9'd0, 32'd9);
    send(FN_SORT_INS_RP, 9'd0, 32'd500);
    send(FN_READ, 9'd255, '0);
    send(FN_READ, 9'd256, '0);

    // Random phases: grow, shrink, sorted traffic, and noise.
    for (int i = 0; i < 1000; i++) begin
      if (i % 80 == 0) begin
        mode = $urandom_range(0, 3);
        narrow = $urandom_range(0, 1);
        no_gaps = ($urandom_range(0, 3) == 0);
        if (mode == 2) send(FN_CLEAR, 9'd0, '0);
      end
      r = $urandom_range(0, 99);
      case (mode)
        0: begin
          if (r < 30) send(FN_PUSH_BACK, pick_pos(), pick_key(narrow));
          else if (r < 50) send(FN_PUSH_FRONT, pick_pos(), pick_key(narrow));
          else if (r < 75) send(FN_INSERT, pick_pos(), pick_key(narrow));
          else send(func_e'($urandom_range(3, 7)), pick_pos(), pick_key(narrow));
        end
        1: begin
          if (r < 25) send(FN_POP_BACK, pick_pos(), pick_key(narrow));
          else if (r < 50) send(FN_POP_FRONT, pick_pos(), pick_key(narrow));
          else if (r < 75) send(FN_REMOVE, pick_pos(), pick_key(narrow));
          else send(func_e'($urandom_range(0, 7)), pick_pos(), pick_key(narrow));
        end
        2: begin
          if (r < 35) send(FN_SORT_INS, pick_pos(), pick_key(narrow));
          else if (r < 60) send(FN_SORT_INS_RP, pick_pos(), pick_key(narrow));
          else if (r < 85) send(FN_SEARCH, pick_pos(), pick_key(narrow));
          else if (r < 92) send(FN_REMOVE, pick_pos(), pick_key(narrow));
          else send(func_e'($urandom_range(3, 6)), pick_pos(), pick_key(narrow));
        end
        default: begin
          if (r < 5) send(4'($urandom_range(12, 15)), pick_pos(), pick_key(narrow));
          else if (r < 8) send(FN_CLEAR, pick_pos(), pick_key(narrow));
          else send(4'($urandom_range(0, 11)), pick_pos(), pick_key(narrow));
        end
      endcase
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: filelist.f
src/rdq_pkg.sv
src/rdq_mem.sv
src/ring_deque_with_sorted_insert.sv
tb/rdq_checker.sv
tb/tb_top.sv
